>>> sv/fkht_pkg.sv
// Shared types, codes and the FNV-1a fold for the keyed hash table.
`timescale 1ns / 1ps
`default_nettype none

package fkht_pkg;

	// Field widths of the beats
	localparam int HASH_W     = 64;
	localparam int ORD_W      = 32;
	localparam int VAL_W      = 32;
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 8;
	localparam int ORD_BYTES  = ORD_W / BYTE_W;

	// FNV-1a 64-bit offset basis
	localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_GET   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} fkht_op_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_FULL     = 3'd2,
		ST_HIT      = 3'd3,
		ST_MISS     = 3'd4
	} fkht_status_t;

	// Input beat
	typedef struct packed {
		fkht_op_t           op;
		logic [ORD_W-1:0]   key_ordinal;
		logic               has_byte;
		logic [BYTE_W-1:0]  name_byte;
		logic               last_byte;
		logic [VAL_W-1:0]   value_index;
	} fkht_in_t;

	// Result beat
	typedef struct packed {
		fkht_status_t       status;
		logic [VAL_W-1:0]   found_index;
	} fkht_out_t;

	// Controller to datapath commands
	typedef struct packed {
		logic               capture;
		logic               acc_init;
		logic               fold_ord;
		logic [1:0]         ord_sel;
		logic               fold_name;
		logic               mod_start;
		logic               probe_load;
		logic               probe_next;
		logic               mem_rd;
		logic               ins_write;
		logic               clr_start;
		logic               clr_write;
		logic               rsp_fire;
		logic               rsp_hit;
		fkht_status_t       rsp_status;
	} fkht_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		fkht_op_t           op;
		logic               has_byte;
		logic               last_byte;
		logic               len_long;
		logic               table_full;
		logic               mod_done;
		logic               slot_empty;
		logic               slot_match;
		logic               probe_last;
		logic               clr_last;
	} fkht_sts_t;

	// XOR a byte in, multiply by the FNV prime 2^40 + 0x1B3 as shifts and adds
	function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
			input logic [BYTE_W-1:0] b);
		logic [HASH_W-1:0] x;
		x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

`default_nettype wire

>>> sv/fkht_mod.sv
// Four-stage unit reducing a 64-bit hash modulo the slot count: weight fold, reciprocal multiply, correction.
`timescale 1ns / 1ps
`default_nettype none

module fkht_mod import fkht_pkg::*; #(
	parameter int MODULUS = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [HASH_W-1:0]           dividend,
	output logic                             done,
	output logic [$clog2(MODULUS)-1:0]       rem
);

	localparam int RW     = $clog2(MODULUS);
	localparam int HBYTES = HASH_W / BYTE_W;
	// Eight bytes times weights below 2^16 stay below 2^27
	localparam int XW     = 27;
	localparam int MW     = 17;
	localparam int RCW    = 26;
	localparam int PW     = XW + RCW;
	localparam logic [MW-1:0]  MOD_C = MW'(MODULUS);
	localparam logic [RCW-1:0] RECIP = RCW'((64'd1 << XW) / 64'(MODULUS));

	// Weight of byte k: 2^(8k) mod MODULUS
	function automatic logic [15:0] byte_weight(input int k);
		longint w;
		w = 1 % MODULUS;
		for (int i = 0; i < k; i++) begin
			w = (w * 256) % MODULUS;
		end
		return 16'(w);
	endfunction

	logic [XW-1:0]  term [HBYTES];
	logic [XW-1:0]  x_sum;
	logic [PW-1:0]  prod;
	logic [XW-1:0]  qm;
	logic [XW-1:0]  r_full;
	logic [RW-1:0]  r_fix;
	logic [XW-1:0]  x_s1;
	logic [XW-1:0]  x_s2;
	logic [RCW-1:0] q_s2;
	logic [MW:0]    r_s3;
	logic [RW-1:0]  rem_q;
	logic           v_s1;
	logic           v_s2;
	logic           v_s3;
	logic           done_q;

	// Each hash byte times its constant weight
	for (genvar k = 0; k < HBYTES; k++) begin : g_term
		localparam logic [15:0] WK = byte_weight(k);
		assign term[k] = XW'(dividend[k*BYTE_W +: BYTE_W]) * XW'(WK);
	end

	always_comb begin
		x_sum = '0;
		for (int k = 0; k < HBYTES; k++) begin
			x_sum = x_sum + term[k];
		end
	end

	// Quotient estimate is low by at most one, so one correction suffices
	assign prod   = PW'(x_s1) * PW'(RECIP);
	assign qm     = XW'(q_s2) * XW'(MOD_C);
	assign r_full = x_s2 - qm;
	assign r_fix  = (r_s3 >= {1'b0, MOD_C}) ? RW'(r_s3 - {1'b0, MOD_C}) : RW'(r_s3);

	// Stage sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
			x_s1   <= '0;
			x_s2   <= '0;
			q_s2   <= '0;
			r_s3   <= '0;
			rem_q  <= '0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
			if (start) begin
				x_s1 <= x_sum;
			end
			if (v_s1) begin
				x_s2 <= x_s1;
				q_s2 <= prod[PW-1:XW];
			end
			if (v_s2) begin
				r_s3 <= r_full[MW:0];
			end
			if (v_s3) begin
				rem_q <= r_fix;
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

>>> sv/fkht_dp.sv
// Datapath: hash accumulator, slot memories, probe pointer and result register.
`timescale 1ns / 1ps
`default_nettype none

module fkht_dp import fkht_pkg::*; #(
	parameter int TABLE_SLOTS  = 64,
	parameter int MAX_GET_NAME = 128
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire fkht_in_t  beat,
	input  wire fkht_cmd_t ctl,
	output fkht_sts_t      sts,
	output logic           done,
	output fkht_out_t      rsp
);

	localparam int IW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam logic [IW-1:0]   LAST_SLOT = IW'(TABLE_SLOTS - 1);
	localparam logic [CW+1:0]   FULL_MARK = (CW+2)'(3 * TABLE_SLOTS);
	localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_GET_NAME);

	fkht_in_t          beat_q;
	logic [HASH_W-1:0] acc_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  len_nx;
	logic [BYTE_W-1:0] fold_byte;
	logic [HASH_W-1:0] h_final;
	logic [IW-1:0]     j_q;
	logic [IW-1:0]     j_inc;
	logic [IW-1:0]     n_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     rem;
	logic              mod_done;
	logic [HASH_W-1:0] hash_mem [TABLE_SLOTS];
	logic [VAL_W-1:0]  val_mem  [TABLE_SLOTS];
	logic [HASH_W-1:0] hash_rd_q;
	logic [VAL_W-1:0]  val_rd_q;
	logic              done_q;
	fkht_out_t         rsp_q;

	// Captured input beat
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			beat_q <= beat;
		end
	end

	// Byte selection and saturating name length
	assign fold_byte = ctl.fold_ord ? beat_q.key_ordinal[{ctl.ord_sel, 3'b000} +: BYTE_W]
	                                : beat_q.name_byte;
	assign len_nx    = (beat_q.has_byte && len_q < LEN_MAX) ? len_q + 1'b1 : len_q;
	assign h_final   = (acc_q == '0) ? HASH_W'(1) : acc_q;

	// Hash accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= FNV_BASIS;
			len_q <= '0;
		end else if (ctl.acc_init) begin
			acc_q <= FNV_BASIS;
			len_q <= '0;
		end else if (ctl.fold_ord || ctl.fold_name) begin
			acc_q <= fnv_fold(acc_q, fold_byte);
			if (ctl.fold_name) begin
				len_q <= len_nx;
			end
		end
	end

	fkht_mod #(
		.MODULUS (TABLE_SLOTS)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.mod_start),
		.dividend (h_final),
		.done     (mod_done),
		.rem      (rem)
	);

	// Slot pointer (probe and clearing sweep), probe count, fill count
	assign j_inc = (j_q == LAST_SLOT) ? '0 : j_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q     <= '0;
			n_q     <= '0;
			count_q <= '0;
		end else begin
			if (ctl.clr_start) begin
				j_q     <= '0;
				count_q <= '0;
			end else if (ctl.probe_load) begin
				j_q <= rem;
				n_q <= '0;
			end else if (ctl.probe_next) begin
				j_q <= j_inc;
				n_q <= n_q + 1'b1;
			end else if (ctl.clr_write) begin
				j_q <= j_inc;
			end
			if (ctl.ins_write) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Hash memory
	always_ff @(posedge clk) begin
		if (ctl.clr_write || ctl.ins_write) begin
			hash_mem[j_q] <= ctl.clr_write ? '0 : h_final;
		end
		if (ctl.mem_rd) begin
			hash_rd_q <= hash_mem[j_q];
		end
	end

	// Value memory
	always_ff @(posedge clk) begin
		if (ctl.ins_write) begin
			val_mem[j_q] <= beat_q.value_index;
		end
		if (ctl.mem_rd) begin
			val_rd_q <= val_mem[j_q];
		end
	end

	// Status back to the controller
	always_comb begin
		sts.op         = beat_q.op;
		sts.has_byte   = beat_q.has_byte;
		sts.last_byte  = beat_q.last_byte;
		sts.len_long   = len_nx >= LEN_MAX;
		sts.table_full = {count_q, 2'b00} >= FULL_MARK;
		sts.mod_done   = mod_done;
		sts.slot_empty = hash_rd_q == '0;
		sts.slot_match = hash_rd_q == h_final;
		sts.probe_last = n_q == LAST_SLOT;
		sts.clr_last   = j_q == LAST_SLOT;
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.rsp_fire;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ctl.rsp_fire) begin
			rsp_q.status      <= ctl.rsp_status;
			rsp_q.found_index <= ctl.rsp_hit ? val_rd_q : '0;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

>>> sv/fkht_ctrl.sv
// Controller state machine: key sequencing, operation decode, probe walk, clearing sweep.
`timescale 1ns / 1ps
`default_nettype none

module fkht_ctrl import fkht_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire fkht_sts_t sts,
	output logic           busy,
	output fkht_cmd_t      ctl
);

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_ORD,
		S_NAME,
		S_MODL,
		S_MOD,
		S_PRD,
		S_PCHK
	} state_t;

	state_t     state_q;
	logic       kip_q;
	logic [1:0] ord_q;

	// Commands per state
	always_comb begin
		ctl            = '0;
		ctl.ord_sel    = ord_q;
		ctl.rsp_status = ST_MISS;
		unique case (state_q)
			S_CLR: begin
				ctl.clr_write = 1'b1;
			end
			S_IDLE: begin
				if (start) begin
					ctl.capture  = 1'b1;
					ctl.acc_init = !kip_q;
				end
			end
			S_ORD: begin
				ctl.fold_ord = 1'b1;
			end
			S_NAME: begin
				ctl.fold_name = sts.has_byte;
				if (sts.last_byte) begin
					unique case (sts.op)
						OP_CLEAR: ctl.clr_start = 1'b1;
						OP_PUT: begin
							if (sts.table_full) begin
								ctl.rsp_fire   = 1'b1;
								ctl.rsp_status = ST_FULL;
							end
						end
						OP_GET: begin
							if (sts.len_long) begin
								ctl.rsp_fire   = 1'b1;
								ctl.rsp_status = ST_MISS;
							end
						end
						OP_NONE: ;
						default: ;
					endcase
				end
			end
			S_MODL: begin
				ctl.mod_start = 1'b1;
			end
			S_MOD: begin
				ctl.probe_load = sts.mod_done;
			end
			S_PRD: begin
				ctl.mem_rd = 1'b1;
			end
			S_PCHK: begin
				priority if (sts.slot_empty) begin
					ctl.rsp_fire = 1'b1;
					if (sts.op == OP_PUT) begin
						ctl.ins_write  = 1'b1;
						ctl.rsp_status = ST_INSERTED;
					end else begin
						ctl.rsp_status = ST_MISS;
					end
				end else if (sts.slot_match) begin
					ctl.rsp_fire = 1'b1;
					if (sts.op == OP_PUT) begin
						ctl.rsp_status = ST_PRESENT;
					end else begin
						ctl.rsp_hit    = 1'b1;
						ctl.rsp_status = ST_HIT;
					end
				end else if (sts.probe_last) begin
					ctl.rsp_fire   = 1'b1;
					ctl.rsp_status = (sts.op == OP_PUT) ? ST_FULL : ST_MISS;
				end else begin
					ctl.probe_next = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// State, key-in-progress flag and ordinal byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			kip_q   <= 1'b0;
			ord_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					if (sts.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= kip_q ? S_NAME : S_ORD;
						kip_q   <= 1'b1;
						ord_q   <= '0;
					end
				end
				S_ORD: begin
					ord_q <= ord_q + 1'b1;
					if (ord_q == 2'(ORD_BYTES - 1)) begin
						state_q <= S_NAME;
					end
				end
				S_NAME: begin
					if (!sts.last_byte) begin
						state_q <= S_IDLE;
					end else begin
						kip_q <= 1'b0;
						unique case (sts.op)
							OP_CLEAR: state_q <= S_CLR;
							OP_PUT:   state_q <= sts.table_full ? S_IDLE : S_MODL;
							OP_GET:   state_q <= sts.len_long ? S_IDLE : S_MODL;
							OP_NONE:  state_q <= S_IDLE;
							default:  state_q <= S_IDLE;
						endcase
					end
				end
				S_MODL: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (sts.mod_done) begin
						state_q <= S_PRD;
					end
				end
				S_PRD: begin
					state_q <= S_PCHK;
				end
				S_PCHK: begin
					if (sts.slot_empty || sts.slot_match || sts.probe_last) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_PRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

`default_nettype wire

>>> sv/fnv_keyed_hash_table.sv
// Top level of the FNV-1a keyed hash table: controller plus datapath.
//
// Usage: drive a beat on cmd and raise start; it is taken at a clock edge
// where start is high and busy is low. A key is a run of beats: the first
// one supplies key_ordinal, every beat may add one name byte, and the beat
// with last_byte set runs op (put, get, clear or nothing).
// A put or get gives one result beat on rsp, marked by done for exactly one
// cycle; the receiver cannot hold it off. Clear and non-final beats give none.
// A middle beat is accepted and then folds its name byte; the first beat of a key
// also folds the four ordinal bytes first, one byte fold per cycle.
// A final put or get then reduces the 64-bit hash modulo TABLE_SLOTS
// (byte-weight fold, reciprocal multiply, one correction) and probes slot after
// slot, each through the registered memory read. A put on a table at
// three-quarters load, or a get of a long name, answers with no probe.
// Clear writes every slot, one slot written per cycle.
// After reset the same clearing pass runs with busy high.
`timescale 1ns / 1ps
`default_nettype none

module fnv_keyed_hash_table import fkht_pkg::*; #(
	parameter int TABLE_SLOTS  = 64,
	parameter int MAX_GET_NAME = 128
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire fkht_in_t cmd,
	output logic          done,
	output fkht_out_t     rsp
);

	fkht_cmd_t ctl;
	fkht_sts_t sts;

	fkht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.ctl    (ctl)
	);

	fkht_dp #(
		.TABLE_SLOTS  (TABLE_SLOTS),
		.MAX_GET_NAME (MAX_GET_NAME)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.beat   (cmd),
		.ctl    (ctl),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

	// A result beat only appears once the controller is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// Result strobes are single cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// Only a hit carries a stored index
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_HIT) |-> rsp.found_index == '0)
		else $error("nonzero index on a non-hit result");

	// An accepted beat always occupies the block next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not start work");

endmodule

`default_nettype wire
